[design/hslci_pkg.sv]
package hslci_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FX_W      = FRAC_BITS + 1;
    localparam int V_W       = FX_W + 1;
    localparam int C_W       = V_W + 1;
    localparam int HO_W      = FX_W + 2;
    localparam int OP_W      = 11;
    localparam int LANES     = 6;
    localparam int DIV_STAGES = FRAC_BITS + 1;
    localparam int CHANNELS  = 3;

    localparam logic [FX_W-1:0] ONE_FX        = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FX_W-1:0] HALF_FX       = FX_W'(1 << (FRAC_BITS - 1));
    localparam logic [FX_W-1:0] THIRD_FX      = FX_W'((1 << FRAC_BITS) / 3);
    localparam logic [FX_W-1:0] TWO_THIRDS_FX = FX_W'((2 << FRAC_BITS) / 3);
    localparam logic [7:0]      CH_MAX        = 8'd255;
    localparam logic [OP_W-1:0] L_DIVISOR     = OP_W'(510);
    localparam logic [15:0]     L_RECIP       = 16'h8081;
    localparam int              L_RECIP_SHIFT = 23;

    localparam int LANE_SA = 0;
    localparam int LANE_LA = 1;
    localparam int LANE_HA = 2;
    localparam int LANE_SB = 3;
    localparam int LANE_LB = 4;
    localparam int LANE_HB = 5;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef struct packed {
        logic [OP_W-1:0] num;
        logic [OP_W-1:0] den;
    } div_op_t;

    typedef struct packed {
        logic [FX_W-1:0] h;
        logic [FX_W-1:0] s;
        logic [FX_W-1:0] l;
    } hsl_t;

endpackage

[design/hslci_analyze.sv]
module hslci_analyze
    import hslci_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [23:0]     color_a,
    input  logic [23:0]     color_b,
    input  logic [16:0]     blend,
    output logic            out_valid,
    output div_op_t         out_op [LANES],
    output logic [FX_W-1:0] out_t
);

    logic            valid_reg;
    div_op_t         op_reg [LANES];
    logic [FX_W-1:0] t_reg;
    div_op_t         op_next [LANES];
    logic [FX_W-1:0] t_next;

    always_comb begin
        logic [23:0]       col;
        logic [7:0]        r, g, b, mx, mn, d;
        logic [8:0]        sum, sumsel;
        logic [OP_W-1:0]   d6;
        logic signed [11:0] n;
        for (int c = 0; c < 2; c++) begin
            col = (c == 0) ? color_a : color_b;
            r = col[23:16];
            g = col[15:8];
            b = col[7:0];
            mx = r;
            mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            d = mx - mn;
            sum = {1'b0, mx} + {1'b0, mn};
            sumsel = (sum < 9'd255) ? sum : 9'd510 - sum;
            d6 = OP_W'({d, 2'b00}) + OP_W'({d, 1'b0});
            n = $signed({4'b0, g}) - $signed({4'b0, b});
            if (mx == g) n = $signed({3'b0, d, 1'b0}) + $signed({4'b0, b}) - $signed({4'b0, r});
            if (mx == b) n = $signed({2'b0, d, 2'b0}) + $signed({4'b0, r}) - $signed({4'b0, g});
            if (n < 0) n = n + $signed({1'b0, d6});
            op_next[c*3 + LANE_LA].num = OP_W'(sum);
            op_next[c*3 + LANE_LA].den = L_DIVISOR;
            if (d == 8'd0) begin
                op_next[c*3 + LANE_SA].num = '0;
                op_next[c*3 + LANE_SA].den = OP_W'(1);
                op_next[c*3 + LANE_HA].num = '0;
                op_next[c*3 + LANE_HA].den = OP_W'(1);
            end else begin
                op_next[c*3 + LANE_SA].num = OP_W'(d);
                op_next[c*3 + LANE_SA].den = OP_W'(sumsel);
                op_next[c*3 + LANE_HA].num = n[OP_W-1:0];
                op_next[c*3 + LANE_HA].den = d6;
            end
        end
        t_next = (blend > 17'(ONE_FX)) ? ONE_FX : FX_W'(blend);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg <= op_next;
            t_reg  <= t_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_op    = op_reg;
    assign out_t     = t_reg;

endmodule

[design/hslci_div.sv]
module hslci_div
    import hslci_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  div_op_t         in_op [LANES],
    input  logic [FX_W-1:0] in_t,
    output logic            out_valid,
    output logic [FX_W-1:0] out_q [LANES],
    output logic [FX_W-1:0] out_t
);

    logic            valid_reg [DIV_STAGES];
    logic [FX_W-1:0] t_reg     [DIV_STAGES];
    logic [OP_W-1:0] den_reg   [DIV_STAGES][LANES];
    logic [OP_W-1:0] rem_reg   [DIV_STAGES][LANES];
    logic [FX_W-1:0] q_reg     [DIV_STAGES][LANES];
    logic [OP_W-1:0] den_next  [DIV_STAGES][LANES];
    logic [OP_W-1:0] rem_next  [DIV_STAGES][LANES];
    logic [FX_W-1:0] q_next    [DIV_STAGES][LANES];

    always_comb begin
        logic [OP_W:0]   cur;
        logic [OP_W-1:0] dd;
        logic [FX_W-1:0] qp;
        logic [15:0]     ly;
        logic [31:0]     lp;
        for (int k = 0; k < DIV_STAGES; k++) begin
            for (int l = 0; l < LANES; l++) begin
                if (k == 0) begin
                    cur = {1'b0, in_op[l].num};
                    dd  = in_op[l].den;
                    qp  = '0;
                end else begin
                    cur = {rem_reg[k-1][l], 1'b0};
                    dd  = den_reg[k-1][l];
                    qp  = q_reg[k-1][l];
                end
                ly = {in_op[l].num[8:0], 7'b0};
                lp = ly * L_RECIP;
                den_next[k][l] = dd;
                if (l == LANE_LA || l == LANE_LB) begin
                    rem_next[k][l] = '0;
                    if (k == 0) begin
                        q_next[k][l] = FX_W'(ly) + FX_W'(lp[31:L_RECIP_SHIFT]);
                    end else begin
                        q_next[k][l] = qp;
                    end
                end else if (cur >= {1'b0, dd}) begin
                    rem_next[k][l] = OP_W'(cur - {1'b0, dd});
                    q_next[k][l]   = {qp[FX_W-2:0], 1'b1};
                end else begin
                    rem_next[k][l] = cur[OP_W-1:0];
                    q_next[k][l]   = {qp[FX_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_STAGES; k++) valid_reg[k] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < DIV_STAGES; k++) valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= den_next;
            rem_reg <= rem_next;
            q_reg   <= q_next;
            t_reg[0] <= in_t;
            for (int k = 1; k < DIV_STAGES; k++) t_reg[k] <= t_reg[k-1];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_q     = q_reg[DIV_STAGES-1];
    assign out_t     = t_reg[DIV_STAGES-1];

endmodule

[design/hslci_mix.sv]
module hslci_mix
    import hslci_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [FX_W-1:0] in_q [LANES],
    input  logic [FX_W-1:0] in_t,
    output logic            out_valid,
    output hsl_t            out_hsl
);

    localparam int P_W  = 2 * FX_W;
    localparam int PH_W = HO_W + FX_W;

    logic              valid1_reg, valid2_reg;
    logic [P_W-1:0]    ps1_reg, ps2_reg, pl1_reg, pl2_reg;
    logic [PH_W-1:0]   ph1_reg, ph2_reg;
    hsl_t              hsl_reg;
    logic [FX_W-1:0]   tn;
    logic [FX_W-1:0]   dh;
    logic [HO_W-1:0]   ha, hb;
    logic [PH_W:0]     hsum;
    logic [HO_W-1:0]   hoff;
    logic [HO_W-1:0]   hw;
    hsl_t              hsl_next;

    always_comb begin
        tn = ONE_FX - in_t;
        dh = (in_q[LANE_HA] > in_q[LANE_HB]) ? in_q[LANE_HA] - in_q[LANE_HB]
                                             : in_q[LANE_HB] - in_q[LANE_HA];
        ha = HO_W'(in_q[LANE_HA]) + HO_W'(ONE_FX);
        if (dh > HALF_FX) begin
            hb = (in_q[LANE_HA] > in_q[LANE_HB])
                 ? HO_W'(in_q[LANE_HB]) + {1'b0, ONE_FX, 1'b0}
                 : HO_W'(in_q[LANE_HB]);
        end else begin
            hb = HO_W'(in_q[LANE_HB]) + HO_W'(ONE_FX);
        end
    end

    always_comb begin
        hsum = {1'b0, ph1_reg} + {1'b0, ph2_reg};
        hoff = hsum[FRAC_BITS +: HO_W];
        if (hoff < HO_W'(ONE_FX)) begin
            hw = hoff;
        end else if (hoff - HO_W'(ONE_FX) > HO_W'(ONE_FX)) begin
            hw = hoff - {1'b0, ONE_FX, 1'b0};
        end else begin
            hw = hoff - HO_W'(ONE_FX);
        end
        hsl_next.h = hw[FX_W-1:0];
        hsl_next.s = FX_W'((ps1_reg + ps2_reg) >> FRAC_BITS);
        hsl_next.l = FX_W'((pl1_reg + pl2_reg) >> FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ps1_reg <= in_q[LANE_SA] * tn;
            ps2_reg <= in_q[LANE_SB] * in_t;
            pl1_reg <= in_q[LANE_LA] * tn;
            pl2_reg <= in_q[LANE_LB] * in_t;
            ph1_reg <= ha * tn;
            ph2_reg <= hb * in_t;
            hsl_reg <= hsl_next;
        end
    end

    assign out_valid = valid2_reg;
    assign out_hsl   = hsl_reg;

endmodule

[design/hslci_to_rgb.sv]
module hslci_to_rgb
    import hslci_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  hsl_t         in_hsl,
    output logic         out_valid,
    output logic [23:0]  out_color
);

    localparam int P_W  = 2 * FX_W;
    localparam int K_W  = V_W + FX_W;
    localparam int B_W  = C_W + 8;

    logic [5:0]        valid_reg;
    logic [P_W-1:0]    p_reg;
    hsl_t              hsl1_reg;
    logic [V_W-1:0]    v1_reg, v2_reg;
    logic [FX_W-1:0]   hc_reg   [CHANNELS];
    logic [V_W-1:0]    span_reg;
    logic [FX_W-1:0]   k_reg    [CHANNELS];
    logic [V_W-1:0]    base_reg [CHANNELS];
    logic [V_W-1:0]    base4_reg [CHANNELS];
    logic [K_W-1:0]    prod_reg [CHANNELS];
    logic [C_W-1:0]    c_reg    [CHANNELS];
    logic [23:0]       color_reg;

    logic [V_W-1:0]    phi, v2_next, v1_next;
    logic signed [V_W:0] v1s;
    logic [FX_W-1:0]   hc_next  [CHANNELS];
    logic [FX_W-1:0]   k_next   [CHANNELS];
    logic [V_W-1:0]    base_next [CHANNELS];
    logic [C_W-1:0]    c_next   [CHANNELS];
    logic [23:0]       color_next;

    always_comb begin
        logic [FX_W:0] hr;
        phi = p_reg[FRAC_BITS +: V_W];
        if (hsl1_reg.l < HALF_FX) begin
            v2_next = V_W'(hsl1_reg.l) + phi;
        end else begin
            v2_next = V_W'(hsl1_reg.l) + V_W'(hsl1_reg.s) - phi;
        end
        v1s = $signed({1'b0, hsl1_reg.l, 1'b0}) - $signed({1'b0, v2_next});
        v1_next = (v1s < 0) ? '0 : v1s[V_W-1:0];
        if (v2_next < v1_next) v2_next = v1_next;
        hr = {1'b0, hsl1_reg.h} + {1'b0, THIRD_FX};
        hc_next[CH_RED] = (hr > {1'b0, ONE_FX}) ? FX_W'(hr - {1'b0, ONE_FX}) : hr[FX_W-1:0];
        hc_next[CH_GREEN] = hsl1_reg.h;
        hc_next[CH_BLUE] = (hsl1_reg.h >= THIRD_FX) ? hsl1_reg.h - THIRD_FX
                                                     : hsl1_reg.h + ONE_FX - THIRD_FX;
    end

    always_comb begin
        logic [FX_W+2:0] h6, h3, h2, kk;
        for (int c = 0; c < CHANNELS; c++) begin
            h6 = (FX_W+3)'(hc_reg[c]) * (FX_W+3)'(6);
            h3 = (FX_W+3)'(hc_reg[c]) * (FX_W+3)'(3);
            h2 = (FX_W+3)'(hc_reg[c]) * (FX_W+3)'(2);
            kk = ((FX_W+3)'(TWO_THIRDS_FX) - (FX_W+3)'(hc_reg[c])) * (FX_W+3)'(6);
            if (h6 < (FX_W+3)'(ONE_FX)) begin
                k_next[c]    = h6[FX_W-1:0];
                base_next[c] = v1_reg;
            end else if (h2 < (FX_W+3)'(ONE_FX)) begin
                k_next[c]    = '0;
                base_next[c] = v2_reg;
            end else if (h3 < (FX_W+3)'({ONE_FX, 1'b0})) begin
                k_next[c]    = kk[FX_W-1:0];
                base_next[c] = v1_reg;
            end else begin
                k_next[c]    = '0;
                base_next[c] = v1_reg;
            end
        end
    end

    always_comb begin
        logic [B_W-1:0] sc;
        logic [B_W-FRAC_BITS-1:0] by;
        color_next = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            c_next[c] = C_W'(base4_reg[c]) + C_W'(prod_reg[c] >> FRAC_BITS);
            sc = B_W'(c_reg[c]) * B_W'(CH_MAX);
            by = sc[B_W-1:FRAC_BITS];
            color_next[(2-c)*8 +: 8] = (by > (B_W-FRAC_BITS)'(CH_MAX)) ? CH_MAX : by[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg     <= in_hsl.s * in_hsl.l;
            hsl1_reg  <= in_hsl;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            hc_reg    <= hc_next;
            span_reg  <= v2_reg - v1_reg;
            k_reg     <= k_next;
            base_reg  <= base_next;
            base4_reg <= base_reg;
            for (int c = 0; c < CHANNELS; c++) begin
                prod_reg[c] <= span_reg * k_reg[c];
            end
            c_reg     <= c_next;
            color_reg <= color_next;
        end
    end

    assign out_valid = valid_reg[5];
    assign out_color = color_reg;

endmodule

[design/hsl_color_interpolation.sv]
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds while an output beat waits on m_tready.
// Depth is set by the 17-stage bit-serial divider that forms hue and
// saturation; each stage resolves one quotient bit, lightness rides alongside.
// Reset (aresetn low, synchronous) clears every valid bit; data is not reset.
module hsl_color_interpolation
    import hslci_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // color_a[23:0], color_b[47:24], blend[64:48], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // color_out[23:0]
);

    logic            en;
    logic            an_valid, dv_valid, mx_valid;
    div_op_t         an_op [LANES];
    logic [FX_W-1:0] an_t, dv_t;
    logic [FX_W-1:0] dv_q [LANES];
    hsl_t            mx_hsl;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    hslci_analyze u_analyze (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .color_a   (s_tdata[23:0]),
        .color_b   (s_tdata[47:24]),
        .blend     (s_tdata[64:48]),
        .out_valid (an_valid),
        .out_op    (an_op),
        .out_t     (an_t)
    );

    hslci_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (an_valid),
        .in_op     (an_op),
        .in_t      (an_t),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_t     (dv_t)
    );

    hslci_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv_valid),
        .in_q      (dv_q),
        .in_t      (dv_t),
        .out_valid (mx_valid),
        .out_hsl   (mx_hsl)
    );

    hslci_to_rgb u_to_rgb (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mx_valid),
        .in_hsl    (mx_hsl),
        .out_valid (m_tvalid),
        .out_color (m_tdata)
    );

endmodule

[design/hslci_checker.sv]
module hslci_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat dropped or changed under stall");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready disagrees with output stall");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind hsl_color_interpolation hslci_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
